// ===== sv/assert_macros.svh =====
// assertion macros used by the checker file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property that must hold at every edge outside reset
`define FFBA_ASSERT(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// implication from a trigger to a consequence in the same cycle
`define FFBA_IMPLY(label, clk, rst, trig, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (trig) |-> (cons)) else $error(msg);

// implication from a trigger to a consequence in the next cycle
`define FFBA_NEXT(label, clk, rst, trig, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (trig) |=> (cons)) else $error(msg);

`endif

// ===== sv/ffba_pkg.sv =====
// shared types and constants of the first fit block allocator
package ffba_pkg;

   localparam int unsigned MAX_BLOCKS_DEF = 64;
   // allocation granule, a power of two
   localparam int unsigned ALIGN_BYTES = 256;
   localparam int unsigned SPLIT_SLACK = 256;
   localparam logic [31:0] POOL_RESET = 32'h8000_0000;

   typedef struct packed {
      logic [31:0] offset;
      logic [31:0] size;
      logic        used;
   } entry_type;

   typedef enum logic [11:0] {
      S_INIT    = 12'b0000_0000_0001,
      S_IDLE    = 12'b0000_0000_0010,
      S_SCAN_RD = 12'b0000_0000_0100,
      S_SCAN_EV = 12'b0000_0000_1000,
      S_NEXT_RD = 12'b0000_0001_0000,
      S_NEXT_EV = 12'b0000_0010_0000,
      S_MV_CHK  = 12'b0000_0100_0000,
      S_MV_RD   = 12'b0000_1000_0000,
      S_MV_WR   = 12'b0001_0000_0000,
      S_FIX     = 12'b0010_0000_0000,
      S_FIX2    = 12'b0100_0000_0000,
      S_RESP    = 12'b1000_0000_0000
   } state_type;

   typedef struct packed {
      logic init;
      logic load;
      logic scan_rd;
      logic scan_ev;
      logic next_rd;
      logic next_ev;
      logic mv_rd;
      logic mv_wr;
      logic fix;
      logic fix2;
   } cmd_type;

   typedef struct packed {
      logic alloc;
      logic hit;
      logic last;
      logic mv_none;
      logic split;
   } sts_type;

endpackage

// ===== sv/ffba_ctrl.sv =====
// sequencing state machine of the allocator
module ffba_ctrl (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_tvalid,
   output logic              req_tready,
   output logic              rsp_tvalid,
   input  logic              rsp_tready,
   input  logic              csr_wr_en,
   input  ffba_pkg::sts_type sts,
   output ffba_pkg::cmd_type cmd
);

   ffba_pkg::state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ffba_pkg::S_INIT;
      end else begin
         state_ff <= state_in;
      end
   end

   assign req_tready = (state_ff == ffba_pkg::S_IDLE) && !csr_wr_en;
   assign rsp_tvalid = (state_ff == ffba_pkg::S_RESP);

   always_comb begin
      state_in = state_ff;
      cmd = '0;
      case (state_ff)
         ffba_pkg::S_INIT: begin
            cmd.init = 1'b1;
            state_in = ffba_pkg::S_IDLE;
         end
         ffba_pkg::S_IDLE: begin
            if (csr_wr_en) begin
               state_in = ffba_pkg::S_INIT;
            end else if (req_tvalid) begin
               cmd.load = 1'b1;
               state_in = ffba_pkg::S_SCAN_RD;
            end
         end
         ffba_pkg::S_SCAN_RD: begin
            cmd.scan_rd = 1'b1;
            state_in = ffba_pkg::S_SCAN_EV;
         end
         ffba_pkg::S_SCAN_EV: begin
            cmd.scan_ev = 1'b1;
            if (sts.hit) begin
               state_in = sts.alloc ? ffba_pkg::S_MV_CHK : ffba_pkg::S_NEXT_RD;
            end else if (sts.last) begin
               state_in = ffba_pkg::S_RESP;
            end else begin
               state_in = ffba_pkg::S_SCAN_RD;
            end
         end
         ffba_pkg::S_NEXT_RD: begin
            cmd.next_rd = 1'b1;
            state_in = ffba_pkg::S_NEXT_EV;
         end
         ffba_pkg::S_NEXT_EV: begin
            cmd.next_ev = 1'b1;
            state_in = ffba_pkg::S_MV_CHK;
         end
         ffba_pkg::S_MV_CHK: begin
            state_in = sts.mv_none ? ffba_pkg::S_FIX : ffba_pkg::S_MV_RD;
         end
         ffba_pkg::S_MV_RD: begin
            cmd.mv_rd = 1'b1;
            state_in = ffba_pkg::S_MV_WR;
         end
         ffba_pkg::S_MV_WR: begin
            cmd.mv_wr = 1'b1;
            state_in = ffba_pkg::S_MV_CHK;
         end
         ffba_pkg::S_FIX: begin
            cmd.fix = 1'b1;
            state_in = sts.split ? ffba_pkg::S_FIX2 : ffba_pkg::S_RESP;
         end
         ffba_pkg::S_FIX2: begin
            cmd.fix2 = 1'b1;
            state_in = ffba_pkg::S_RESP;
         end
         ffba_pkg::S_RESP: begin
            if (rsp_tready) begin
               state_in = ffba_pkg::S_IDLE;
            end
         end
         default: begin
            state_in = ffba_pkg::S_INIT;
         end
      endcase
   end

endmodule

// ===== sv/ffba_dpath.sv =====
// block table memory, statistics and request registers of the allocator
module ffba_dpath #(
   parameter int unsigned MAX_BLOCKS = ffba_pkg::MAX_BLOCKS_DEF
) (
   input  logic              clock,
   input  logic              reset,
   input  ffba_pkg::cmd_type cmd,
   output ffba_pkg::sts_type sts,
   input  logic              req_action,
   input  logic [31:0]       req_bytes,
   input  logic [31:0]       req_offset,
   input  logic              csr_wr_en,
   input  logic [31:0]       csr_wr_data,
   output logic              rsp_ok,
   output logic [31:0]       rsp_granted,
   output logic [31:0]       rsp_in_use,
   output logic [31:0]       rsp_peak,
   output logic [31:0]       rsp_free,
   output logic [6:0]        rsp_free_cnt,
   output logic [6:0]        rsp_blocks
);

   localparam int unsigned IW = (MAX_BLOCKS > 1) ? $clog2(MAX_BLOCKS) : 1;
   localparam int unsigned CW = $clog2(MAX_BLOCKS + 1);
   localparam logic [32:0] ALIGN_MASK = 33'(ffba_pkg::ALIGN_BYTES - 1);

   ffba_pkg::entry_type mem [MAX_BLOCKS];
   ffba_pkg::entry_type rd_ff, cur_ff, prev_ff, fix_data_ff, wr_data;
   logic [IW-1:0] rd_addr, wr_addr, idx_ff, fix_addr_ff, mv_src_ff, mv_dst_ff;
   logic          rd_en, wr_en;
   logic [CW-1:0] total_ff, free_ff, mv_left_ff, idx_ext, dst_c, src_c, drop_c;
   logic [31:0]   pool_ff, used_ff, peak_ff, grant_ff, taken, used_n;
   logic [32:0]   need_ff;
   logic          alloc_ff, zero_ff, ok_ff, split_ff, mv_up_ff;
   logic          fits, match, hit, split_c, nxt_valid, mn, mp;
   logic [31:0]   size2;
   logic [31:0]   req_offset_ff;

   // table memory, one write and one registered read per cycle
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_ff <= mem[rd_addr];
      end
   end

   always_comb begin
      rd_en = cmd.scan_rd | cmd.next_rd | cmd.mv_rd;
      rd_addr = idx_ff;
      if (cmd.next_rd) begin
         rd_addr = idx_ff + IW'(1);
      end else if (cmd.mv_rd) begin
         rd_addr = mv_src_ff;
      end
      wr_en = cmd.init | cmd.mv_wr | cmd.fix | cmd.fix2;
      wr_addr = '0;
      wr_data = '{offset: 32'd0, size: pool_ff, used: 1'b0};
      if (cmd.mv_wr) begin
         wr_addr = mv_dst_ff;
         wr_data = rd_ff;
      end else if (cmd.fix) begin
         wr_addr = fix_addr_ff;
         wr_data = fix_data_ff;
      end else if (cmd.fix2) begin
         wr_addr = idx_ff;
         wr_data = '{offset: cur_ff.offset, size: need_ff[31:0], used: 1'b1};
      end
   end

   // scan evaluation
   assign idx_ext = CW'(idx_ff);
   assign fits    = !rd_ff.used && ({1'b0, rd_ff.size} >= need_ff) && !zero_ff;
   assign match   = rd_ff.used && (rd_ff.offset == req_offset_ff);
   assign hit     = alloc_ff ? fits : match;
   assign split_c = ({2'b0, rd_ff.size} > ({1'b0, need_ff} + 34'(ffba_pkg::SPLIT_SLACK)))
                    && (total_ff < CW'(MAX_BLOCKS));
   assign taken   = split_c ? need_ff[31:0] : rd_ff.size;
   assign used_n  = used_ff + taken;

   // merge evaluation for a free
   assign nxt_valid = (idx_ext + CW'(1)) < total_ff;
   assign mn = nxt_valid && !rd_ff.used &&
               (({1'b0, cur_ff.offset} + {1'b0, cur_ff.size}) == {1'b0, rd_ff.offset});
   assign mp = (idx_ff != '0) && !prev_ff.used &&
               (({1'b0, prev_ff.offset} + {1'b0, prev_ff.size}) == {1'b0, cur_ff.offset});
   assign size2  = cur_ff.size + (mn ? rd_ff.size : 32'd0);
   assign drop_c = CW'(mn) + CW'(mp);
   assign dst_c  = mp ? idx_ext : idx_ext + CW'(1);
   assign src_c  = dst_c + drop_c;

   always_ff @(posedge clock) begin
      if (reset) begin
         pool_ff  <= ffba_pkg::POOL_RESET;
         total_ff <= CW'(1);
         free_ff  <= CW'(1);
         used_ff  <= '0;
         peak_ff  <= '0;
         mv_left_ff <= '0;
         split_ff <= 1'b0;
      end else begin
         if (csr_wr_en) begin
            pool_ff <= csr_wr_data;
         end
         if (cmd.init) begin
            total_ff <= CW'(1);
            free_ff  <= CW'(1);
            used_ff  <= '0;
            peak_ff  <= '0;
         end
         if (cmd.load) begin
            mv_left_ff <= '0;
            split_ff   <= 1'b0;
         end
         if (cmd.scan_ev && hit) begin
            if (alloc_ff) begin
               used_ff <= used_n;
               if (used_n > peak_ff) begin
                  peak_ff <= used_n;
               end
               split_ff <= split_c;
               if (split_c) begin
                  total_ff   <= total_ff + CW'(1);
                  mv_left_ff <= total_ff - CW'(1) - idx_ext;
               end else begin
                  free_ff <= free_ff - CW'(1);
               end
            end else begin
               used_ff <= used_ff - rd_ff.size;
            end
         end
         if (cmd.next_ev) begin
            total_ff   <= total_ff - drop_c;
            free_ff    <= free_ff + CW'(1) - drop_c;
            mv_left_ff <= (drop_c == '0) ? '0 : total_ff - src_c;
         end
         if (cmd.mv_wr) begin
            mv_left_ff <= mv_left_ff - CW'(1);
         end
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      if (cmd.load) begin
         alloc_ff      <= !req_action;
         zero_ff       <= (req_bytes == 32'd0);
         need_ff       <= ({1'b0, req_bytes} + ALIGN_MASK) & ~ALIGN_MASK;
         req_offset_ff <= req_offset;
         idx_ff        <= '0;
         ok_ff         <= 1'b0;
         grant_ff      <= '0;
      end
      if (cmd.scan_ev) begin
         if (hit) begin
            cur_ff <= rd_ff;
            ok_ff  <= 1'b1;
            if (alloc_ff) begin
               grant_ff  <= rd_ff.offset;
               mv_up_ff  <= 1'b1;
               mv_src_ff <= IW'(total_ff - CW'(1));
               mv_dst_ff <= IW'(total_ff);
               if (split_c) begin
                  fix_addr_ff <= idx_ff + IW'(1);
                  fix_data_ff <= '{offset: rd_ff.offset + need_ff[31:0],
                                   size: rd_ff.size - need_ff[31:0], used: 1'b0};
               end else begin
                  fix_addr_ff <= idx_ff;
                  fix_data_ff <= '{offset: rd_ff.offset, size: rd_ff.size, used: 1'b1};
               end
            end
         end else begin
            prev_ff <= rd_ff;
            idx_ff  <= idx_ff + IW'(1);
         end
      end
      if (cmd.next_ev) begin
         mv_up_ff  <= 1'b0;
         mv_dst_ff <= IW'(dst_c);
         mv_src_ff <= IW'(src_c);
         if (mp) begin
            fix_addr_ff <= idx_ff - IW'(1);
            fix_data_ff <= '{offset: prev_ff.offset, size: prev_ff.size + size2, used: 1'b0};
         end else begin
            fix_addr_ff <= idx_ff;
            fix_data_ff <= '{offset: cur_ff.offset, size: size2, used: 1'b0};
         end
      end
      if (cmd.mv_wr) begin
         if (mv_up_ff) begin
            mv_src_ff <= mv_src_ff - IW'(1);
            mv_dst_ff <= mv_dst_ff - IW'(1);
         end else begin
            mv_src_ff <= mv_src_ff + IW'(1);
            mv_dst_ff <= mv_dst_ff + IW'(1);
         end
      end
   end

   always_comb begin
      sts.alloc   = alloc_ff;
      sts.hit     = hit;
      sts.last    = !nxt_valid;
      sts.mv_none = (mv_left_ff == '0);
      sts.split   = split_ff;
   end

   assign rsp_ok          = ok_ff;
   assign rsp_granted     = grant_ff;
   assign rsp_in_use      = used_ff;
   assign rsp_peak        = peak_ff;
   assign rsp_free        = pool_ff - used_ff;
   assign rsp_free_cnt    = 7'(free_ff);
   assign rsp_blocks      = 7'(total_ff);

endmodule

// ===== sv/first_fit_block_allocator_unit.sv =====
// top level of the first fit block allocator with coalescing
// each table entry scanned passes a read and an evaluate state, each entry shifted a check, read and write state
// a request is taken only when the previous response has been delivered
// reset (synchronous, active high) and a pool size write taken while idle rebuild the table as
// one free block in the init state; requests are held off during the write and the init state
module first_fit_block_allocator_unit #(
   parameter int unsigned MAX_BLOCKS = ffba_pkg::MAX_BLOCKS_DEF
) (
   input  logic         clock,
   input  logic         reset,
   // request transaction
   input  logic         req_tvalid,
   output logic         req_tready,
   input  logic [63:0]  req_tdata,   // request_bytes, block_offset
   input  logic         req_tuser,   // action: 0 allocate, 1 free
   // response transaction
   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   output logic [143:0] rsp_tdata,   // granted_offset, bytes_in_use, peak_in_use,
                                     // bytes_free, free_block_count, block_count, zero fill
   output logic         rsp_tuser,   // ok
   // pool size register
   input  logic         csr_wr_en,
   input  logic [31:0]  csr_wr_data
);

   ffba_pkg::cmd_type cmd;
   ffba_pkg::sts_type sts;
   logic [31:0] granted, in_use, peak, free_bytes;
   logic [6:0]  free_cnt, blocks;

   // state machine: accepts, walks the table, hands back the response
   ffba_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .csr_wr_en  (csr_wr_en),
      .sts        (sts),
      .cmd        (cmd)
   );

   // table memory and statistics; result registers hold while waiting for rsp_tready
   ffba_dpath #(
      .MAX_BLOCKS (MAX_BLOCKS)
   ) u_dpath (
      .clock           (clock),
      .reset           (reset),
      .cmd             (cmd),
      .sts             (sts),
      .req_action      (req_tuser),
      .req_bytes       (req_tdata[31:0]),
      .req_offset      (req_tdata[63:32]),
      .csr_wr_en       (csr_wr_en),
      .csr_wr_data     (csr_wr_data),
      .rsp_ok          (rsp_tuser),
      .rsp_granted     (granted),
      .rsp_in_use      (in_use),
      .rsp_peak        (peak),
      .rsp_free        (free_bytes),
      .rsp_free_cnt    (free_cnt),
      .rsp_blocks      (blocks)
   );

   // pack result fields from the lowest bit up
   assign rsp_tdata = {2'b00, blocks, free_cnt, free_bytes, peak, in_use, granted};

endmodule

// ===== sv/ffba_checker.sv =====
// port checker of the allocator, bound to the top level
`include "assert_macros.svh"

module ffba_checker (
   input logic         clock,
   input logic         reset,
   input logic         req_tready,
   input logic         rsp_tvalid,
   input logic         rsp_tready,
   input logic [143:0] rsp_tdata,
   input logic         rsp_tuser,
   input logic         csr_wr_en
);

   // response stays offered until taken
   `FFBA_NEXT(a_rsp_hold, clock, reset, rsp_tvalid && !rsp_tready, rsp_tvalid, "response dropped")
   // one transaction in flight at a time
   `FFBA_ASSERT(a_one_item, clock, reset, !(req_tready && rsp_tvalid), "request taken during response")
   // failed responses carry no offset
   `FFBA_IMPLY(a_fail_zero, clock, reset, rsp_tvalid && !rsp_tuser, rsp_tdata[31:0] == 32'd0, "offset on failure")
   // peak never below current use
   `FFBA_IMPLY(a_peak, clock, reset, rsp_tvalid, rsp_tdata[95:64] >= rsp_tdata[63:32], "peak below use")
   // no request taken while the pool size is written
   `FFBA_IMPLY(a_csr_block, clock, reset, csr_wr_en, !req_tready, "request taken during pool write")

endmodule

bind first_fit_block_allocator_unit ffba_checker u_ffba_checker (.*);

// ===== verif/first_fit_block_allocator_unit_tb.sv =====
// testbench for the first fit block allocator: random and directed requests checked against a predictor
`timescale 1ns / 1ps

module first_fit_block_allocator_unit_tb;

   localparam int unsigned TABLE_DEPTH = ffba_pkg::MAX_BLOCKS_DEF;
   localparam logic ACT_ALLOC = 1'b0;
   localparam logic ACT_FREE  = 1'b1;

   typedef struct packed {
      logic        action;
      logic [31:0] request_bytes;
      logic [31:0] block_offset;
   } request_type;

   typedef struct packed {
      logic        ok;
      logic [31:0] granted_offset;
      logic [31:0] bytes_in_use;
      logic [31:0] peak_in_use;
      logic [31:0] bytes_free;
      logic [6:0]  free_block_count;
      logic [6:0]  block_count;
   } response_type;

   logic clock = 0;
   logic reset = 1;
   logic req_tvalid = 0;
   logic req_tready;
   logic [63:0] req_tdata = '0;
   logic req_tuser = 0;
   logic rsp_tvalid;
   logic rsp_tready = 0;
   logic [143:0] rsp_tdata;
   logic rsp_tuser;
   logic csr_wr_en = 0;
   logic [31:0] csr_wr_data = '0;

   first_fit_block_allocator_unit dut (
      .clock(clock), .reset(reset),
      .req_tvalid(req_tvalid), .req_tready(req_tready),
      .req_tdata(req_tdata), .req_tuser(req_tuser),
      .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready),
      .rsp_tdata(rsp_tdata), .rsp_tuser(rsp_tuser),
      .csr_wr_en(csr_wr_en), .csr_wr_data(csr_wr_data)
   );

   // predictor copy of the allocation table
   logic [31:0] pool_bytes;
   logic [31:0] blk_offset [TABLE_DEPTH];
   logic [31:0] blk_size [TABLE_DEPTH];
   logic        blk_used [TABLE_DEPTH];
   int unsigned blk_total;
   logic [31:0] in_use_bytes;
   logic [31:0] in_use_peak;

   request_type  pending_requests[$];
   response_type expected_responses[$];
   logic [31:0] live_offsets[$];   // offsets the predictor holds in use, for well-formed frees
   int  error_count = 0;

   // stimulus phase controls
   int  send_idle_pct = 0;
   int  recv_stall_pct = 0;
   int  hold_cycles = 0;            // long receiver hold-off, counted in the monitor

   initial begin
      forever #5 clock = ~clock;
   end

   function automatic void clear_pool(input logic [31:0] size);
      pool_bytes = size;
      for (int i = 0; i < TABLE_DEPTH; i++) begin
         blk_offset[i] = '0;
         blk_size[i] = '0;
         blk_used[i] = 1'b0;
      end
      blk_size[0] = size;
      blk_total = 1;
      in_use_bytes = '0;
      in_use_peak = '0;
      live_offsets.delete();
   endfunction

   function automatic void remove_block(input int unsigned k);
      for (int unsigned i = k; i + 1 < blk_total; i++) begin
         blk_offset[i] = blk_offset[i+1];
         blk_size[i] = blk_size[i+1];
         blk_used[i] = blk_used[i+1];
      end
      blk_total--;
      blk_offset[blk_total] = '0;
      blk_size[blk_total] = '0;
      blk_used[blk_total] = 1'b0;
   endfunction

   function automatic void forget_offset(input logic [31:0] off);
      foreach (live_offsets[k])
         if (live_offsets[k] == off) begin
            live_offsets.delete(k);
            return;
         end
   endfunction

   // appends one request to the driver queue
   function automatic void queue_request(input request_type r);
      pending_requests.insert(pending_requests.size(), r);
   endfunction

   // computes the response of one request and updates the table
   function automatic response_type allocate_or_free(input request_type r);
      response_type rsp;
      logic [33:0] need;
      int unsigned nfree;
      rsp = '0;
      if (r.action == ACT_ALLOC) begin
         if (r.request_bytes != 0) begin
            need = ({2'b0, r.request_bytes} + 34'd255) & ~34'd255;
            for (int unsigned i = 0; i < blk_total; i++) begin
               if (blk_used[i] || {2'b0, blk_size[i]} < need) continue;
               blk_used[i] = 1'b1;
               // split only when the excess is worth a block and the table has room
               if ({2'b0, blk_size[i]} > need + 34'd256 && blk_total < TABLE_DEPTH) begin
                  for (int unsigned j = blk_total; j > i + 1; j--) begin
                     blk_offset[j] = blk_offset[j-1];
                     blk_size[j] = blk_size[j-1];
                     blk_used[j] = blk_used[j-1];
                  end
                  blk_offset[i+1] = blk_offset[i] + need[31:0];
                  blk_size[i+1] = blk_size[i] - need[31:0];
                  blk_used[i+1] = 1'b0;
                  blk_size[i] = need[31:0];
                  blk_total++;
               end
               in_use_bytes += blk_size[i];
               if (in_use_bytes > in_use_peak) in_use_peak = in_use_bytes;
               rsp.ok = 1'b1;
               rsp.granted_offset = blk_offset[i];
               live_offsets.insert(live_offsets.size(), blk_offset[i]);
               break;
            end
         end
      end else begin
         for (int unsigned i = 0; i < blk_total; i++) begin
            if (blk_offset[i] != r.block_offset || !blk_used[i]) continue;
            blk_used[i] = 1'b0;
            in_use_bytes -= blk_size[i];
            forget_offset(r.block_offset);
            // merge with the following free block, then the preceding one
            if (i + 1 < blk_total && !blk_used[i+1] &&
                {1'b0, blk_offset[i]} + blk_size[i] == {1'b0, blk_offset[i+1]}) begin
               blk_size[i] += blk_size[i+1];
               remove_block(i + 1);
            end
            if (i > 0 && !blk_used[i-1] &&
                {1'b0, blk_offset[i-1]} + blk_size[i-1] == {1'b0, blk_offset[i]}) begin
               blk_size[i-1] += blk_size[i];
               remove_block(i);
            end
            rsp.ok = 1'b1;
            break;
         end
      end
      nfree = 0;
      for (int unsigned i = 0; i < blk_total; i++)
         if (!blk_used[i]) nfree++;
      rsp.bytes_in_use = in_use_bytes;
      rsp.peak_in_use = in_use_peak;
      rsp.bytes_free = pool_bytes - in_use_bytes;
      rsp.free_block_count = nfree[6:0];
      rsp.block_count = blk_total[6:0];
      return rsp;
   endfunction

   // driver: offers queued requests, predicts each at its accepting edge
   always @(posedge clock) begin
      if (reset) begin
         req_tvalid <= 1'b0;
      end else begin
         if (req_tvalid && req_tready) begin
            expected_responses.insert(expected_responses.size(),
                                      allocate_or_free(pending_requests.pop_front()));
         end
         if ((!req_tvalid || req_tready) ) begin
            // pending_requests head is the next request once the accepted one was popped
            if (pending_requests.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
               req_tvalid <= 1'b1;
               req_tuser <= pending_requests[0].action;
               req_tdata <= {pending_requests[0].block_offset, pending_requests[0].request_bytes};
            end else begin
               req_tvalid <= 1'b0;
            end
         end
      end
   end

   // monitor: compares each response with the oldest expectation
   always @(posedge clock) begin
      response_type got, want;
      if (reset) begin
         rsp_tready <= 1'b0;
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            got.ok = rsp_tuser;
            got.granted_offset = rsp_tdata[31:0];
            got.bytes_in_use = rsp_tdata[63:32];
            got.peak_in_use = rsp_tdata[95:64];
            got.bytes_free = rsp_tdata[127:96];
            got.free_block_count = rsp_tdata[134:128];
            got.block_count = rsp_tdata[141:135];
            if (expected_responses.size() == 0) begin
               $display("%0t: unexpected response, actual %p", $time, got);
               error_count++;
            end else begin
               want = expected_responses.pop_front();
               if (got !== want) begin
                  $display("%0t: response mismatch, expected %p, actual %p", $time, want, got);
                  error_count++;
               end
            end
         end
         if (hold_cycles > 0) begin
            hold_cycles--;
            rsp_tready <= 1'b0;
         end else begin
            rsp_tready <= ($urandom_range(99) >= recv_stall_pct);
         end
      end
   end

   function automatic request_type alloc_req(input logic [31:0] bytes);
      request_type r;
      r.action = ACT_ALLOC;
      r.request_bytes = bytes;
      r.block_offset = $urandom;
      return r;
   endfunction

   function automatic request_type free_req(input logic [31:0] off);
      request_type r;
      r.action = ACT_FREE;
      r.request_bytes = $urandom;
      r.block_offset = off;
      return r;
   endfunction

   // waits until every sent request has been answered
   task automatic drain();
      while (pending_requests.size() > 0 || req_tvalid || expected_responses.size() > 0)
         @(posedge clock);
      repeat (300) @(posedge clock);
   endtask

   task automatic write_pool(input logic [31:0] size);
      @(posedge clock);
      csr_wr_en <= 1'b1;
      csr_wr_data <= size;
      @(posedge clock);
      csr_wr_en <= 1'b0;
      clear_pool(size);
   endtask

   // random mix: mostly sized allocates and frees at 256-byte aligned offsets, some noise
   task automatic random_phase(input int count, input logic [31:0] pool);
      int unsigned live_seen;
      request_type r;
      live_seen = 0;
      for (int n = 0; n < count; n++) begin
         case ($urandom_range(9))
            0, 1, 2, 3: r = alloc_req($urandom_range(1, 4096));
            4:          r = alloc_req($urandom_range(0, 3) == 0 ? $urandom : pool >> $urandom_range(1, 6));
            5, 6, 7:    r = free_req(live_seen * 256);
            8:          r = free_req($urandom_range(0, 63) * 256);
            default:    r = free_req($urandom);
         endcase
         live_seen = $urandom_range(0, 40);
         queue_request(r);
      end
   endtask

   initial begin
      clear_pool(ffba_pkg::POOL_RESET);
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed: field extremes, zero size, oversize, unsplit, bad frees
      queue_request(alloc_req(32'd0));
      queue_request(alloc_req(32'hFFFF_FFFF));
      queue_request(alloc_req(32'h8000_0000));
      queue_request(free_req(32'd0));
      queue_request(free_req(32'd0));
      queue_request(free_req(32'hFFFF_FFFF));
      queue_request(alloc_req(32'd1));
      queue_request(alloc_req(32'd257));
      queue_request(alloc_req(32'd256));
      queue_request(free_req(32'd256));
      queue_request(free_req(32'd0));
      queue_request(free_req(32'd768));
      drain();

      // small pool: small excess keeps the block whole
      write_pool(32'd1024);
      queue_request(alloc_req(32'd600));
      queue_request(alloc_req(32'd200));
      queue_request(free_req(32'd0));
      queue_request(alloc_req(32'd1024));
      drain();

      // table full: fill all entries with 256-byte blocks but the last, which keeps the rest of the pool
      write_pool(32'd65536);
      for (int k = 0; k < 66; k++) queue_request(alloc_req(32'd100));
      for (int k = 0; k < 64; k += 2) queue_request(free_req(k * 256));
      drain();

      // zero pool, then the top of the range
      write_pool(32'd0);
      queue_request(alloc_req(32'd1));
      drain();
      write_pool(32'hFFFF_FF00);
      queue_request(alloc_req(32'hFFFF_FF00));
      queue_request(free_req(32'd0));
      drain();

      // random phases over several pool sizes and idling mixes
      write_pool(32'd16384);
      send_idle_pct = 0; recv_stall_pct = 0;
      random_phase(400, 32'd16384);
      drain();
      write_pool(32'd256);
      send_idle_pct = 55; recv_stall_pct = 0;
      random_phase(300, 32'd256);
      drain();
      write_pool(32'd8192);
      send_idle_pct = 0; recv_stall_pct = 55;
      random_phase(400, 32'd8192);
      // long receiver hold-off while requests keep coming
      hold_cycles = 2000;
      drain();
      write_pool(ffba_pkg::POOL_RESET);
      send_idle_pct = 20; recv_stall_pct = 20;
      random_phase(500, 32'd16384);
      drain();

      if (error_count == 0) begin
         $display("tb: success");
      end else begin
         $display("tb: failure");
      end
      $finish;
   end

   initial begin
      #20ms;
      $display("tb: failure");
      $finish;
   end

endmodule

// ===== files.f =====
+incdir+sv
sv/ffba_pkg.sv
sv/ffba_ctrl.sv
sv/ffba_dpath.sv
sv/first_fit_block_allocator_unit.sv
sv/ffba_checker.sv
verif/first_fit_block_allocator_unit_tb.sv
